@@ rtl/core/pli_pkg.sv @@
`timescale 1ns / 1ps

package pli_pkg;

  localparam int DATA_W    = 24;
  localparam int MODE_W    = 2;
  localparam int ROW_W     = 8;
  localparam int PT_W      = 4;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 5;
  localparam int DEN_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * DEN_W;
  localparam int QUO_W     = DEN_W;
  localparam int ROW_TAB_N = 1 << ROW_W;

  localparam int POINTS_DEF = 16;
  localparam int ROWS_DEF   = 256;

  localparam logic [CNT_W-1:0] PIU_RESET = CNT_W'(16);

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 24'sh7fffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 24'sh800000;

  typedef enum logic [MODE_W-1:0] {
    MODE_BP    = 2'd0,
    MODE_VAL   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [ROW_W-1:0]         row;
    logic [PT_W-1:0]          point;
    logic signed [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interpolated;
    logic [STAT_W-1:0]        status;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // row number folded into the table range, one entry per possible row field
  typedef logic [11:0] row_tab_t [ROW_TAB_N];

  function automatic row_tab_t row_tab(int rows);
    row_tab_t t;
    int       r;
    r = 0;
    for (int i = 0; i < ROW_TAB_N; i++) begin
      t[i] = 12'(r);
      r = r + 1;
      if (r == rows) begin
        r = 0;
      end
    end
    return t;
  endfunction

endpackage

@@ rtl/core/pli_if.sv @@
`timescale 1ns / 1ps

interface pli_item_if import pli_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [ROW_W-1:0]         row;
  logic [PT_W-1:0]          point;
  logic signed [DATA_W-1:0] data;

  modport source (output valid, mode, row, point, data, input ready);
  modport sink   (input valid, mode, row, point, data, output ready);
endinterface

interface pli_result_if import pli_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interpolated;
  logic [STAT_W-1:0]        status;

  modport source (output valid, interpolated, status, input ready);
  modport sink   (input valid, interpolated, status, output ready);
endinterface

interface pli_cfg_if import pli_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/pli_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle. A quotient that would not fit
// in QUO_W bits is flagged as overflow at once.
module pli_div import pli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output div_stat_t        stat_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int LOW_W = PROD_W - DEN_W;

  logic                busy_q;
  logic                done_q;
  logic                ovf_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DEN_W-1:0]    dvs_q;
  logic [LOW_W-1:0]    sh_q;
  logic [QUO_W-1:0]    quo_q;

  logic [DEN_W:0]      trial;
  logic                fits;

  assign trial = {rem_q, sh_q[LOW_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvs_q <= req_i.divisor;
        sh_q  <= req_i.dividend[LOW_W-1:0];
        quo_q <= '0;
        if (req_i.dividend[PROD_W-1:LOW_W] >= req_i.divisor) begin
          ovf_q  <= 1'b1;
          done_q <= 1'b1;
        end else begin
          ovf_q  <= 1'b0;
          rem_q  <= req_i.dividend[PROD_W-1:LOW_W];
          cnt_q  <= CNT_W'(LOW_W);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= fits ? DEN_W'(trial - {1'b0, dvs_q}) : DEN_W'(trial);
        quo_q <= {quo_q[QUO_W-2:0], fits};
        sh_q  <= {sh_q[LOW_W-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quo_o       = quo_q;

endmodule

@@ rtl/core/pli_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: store writes, linear segment search, value fetch, product,
// then the rounding divider, then saturation back into range.
module pli_ctrl import pli_pkg::*; #(
  parameter int POINTS = POINTS_DEF,
  parameter int ROWS   = ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  item_t            item_i,
  input  logic [CNT_W-1:0] piu_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o,
  output div_req_t         div_req_o,
  input  div_stat_t        div_stat_i,
  input  logic [QUO_W-1:0] div_quo_i
);

  localparam int PW     = $clog2(POINTS);
  localparam int CW     = $clog2(POINTS + 1);
  localparam int LW     = (CW > CNT_W) ? CW : CNT_W;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VDEPTH = ROWS * POINTS;
  localparam int AW     = $clog2(VDEPTH);
  localparam row_tab_t ROW_TAB = row_tab(ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SRCH, S_V0, S_V1, S_MUL, S_DIV0, S_DIV, S_OUT
  } state_e;

  state_e                    state_q;
  item_t                     item_q;
  logic [AW-1:0]             base_q;
  logic [PW-1:0]             k_q;
  logic [PW-1:0]             seg_q;
  logic signed [DATA_W-1:0]  first_q, second_q, prev_q, b0_q, b1_q, v0_q;
  logic signed [DEN_W-1:0]   den_q, dx_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      neg_q;
  logic                      res_valid_q;
  result_t                   res_q;

  logic signed [DATA_W-1:0]  bp_mem [POINTS];
  logic signed [DATA_W-1:0]  val_mem [VDEPTH];
  logic signed [DATA_W-1:0]  bp_rd_q, val_rd_q;

  logic [RW-1:0]             rowm;
  logic [AW-1:0]             base, wr_addr, va;
  logic [PW-1:0]             bp_ra, nm1;
  logic [LW-1:0]             piu_ext;
  logic                      pt_ok, bp_we, val_we, hit;
  logic signed [DATA_W-1:0]  x, cur;
  logic signed [DEN_W-1:0]   dv;
  logic [PROD_W-1:0]         am;
  logic [DEN_W-1:0]          ad;
  logic signed [DATA_W+2:0]  sum, qx;

  assign rowm    = RW'(ROW_TAB[item_q.row]);
  assign base    = AW'(rowm) * AW'(POINTS);
  assign wr_addr = base + AW'(item_q.point);
  assign pt_ok   = {28'd0, item_q.point} < 32'(POINTS);
  assign bp_we   = (state_q == S_PREP) && (item_q.mode == MODE_BP) && pt_ok;
  assign val_we  = (state_q == S_PREP) && (item_q.mode == MODE_VAL) && pt_ok;

  // points in use, clamped to [2, POINTS], held as the last index
  assign piu_ext = LW'(piu_i);
  always_comb begin
    if (piu_ext < LW'(2)) begin
      nm1 = PW'(1);
    end else if (piu_ext > LW'(POINTS)) begin
      nm1 = PW'(POINTS - 1);
    end else begin
      nm1 = PW'(piu_ext - LW'(1));
    end
  end

  assign x   = item_q.data;
  assign cur = bp_rd_q;
  assign hit = (prev_q >= x) && (x >= cur);

  always_comb begin
    bp_ra = '0;
    if (state_q == S_SRCH && k_q != nm1) begin
      bp_ra = k_q + PW'(1);
    end
  end

  always_comb begin
    va = base_q + AW'(seg_q);
    if (state_q == S_V1) begin
      va = base_q + AW'(seg_q) + AW'(1);
    end
  end

  assign dv = DEN_W'(val_rd_q) - DEN_W'(v0_q);
  assign am = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign ad = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);

  assign div_req_o.start    = (state_q == S_DIV0);
  assign div_req_o.dividend = am + {{(PROD_W - DEN_W + 1){1'b0}}, ad[DEN_W-1:1]};
  assign div_req_o.divisor  = ad;

  assign qx  = $signed({2'b00, div_quo_i});
  assign sum = neg_q ? (DATA_W+3)'(v0_q) - qx : (DATA_W+3)'(v0_q) + qx;

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[PW'(item_q.point)] <= item_q.data;
    end
    bp_rd_q <= bp_mem[bp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_addr] <= item_q.data;
    end
    val_rd_q <= val_mem[va];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= item_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          base_q <= base;
          k_q    <= '0;
          if (item_q.mode == MODE_QUERY) begin
            state_q <= S_SRCH;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SRCH: begin
          if (k_q == '0) begin
            first_q <= cur;
            prev_q  <= cur;
            k_q     <= PW'(1);
          end else begin
            if (k_q == PW'(1)) begin
              second_q <= cur;
            end
            if (hit) begin
              seg_q   <= k_q - PW'(1);
              b0_q    <= prev_q;
              b1_q    <= cur;
              state_q <= S_V0;
            end else if (k_q == nm1) begin
              // no enclosing segment: extrapolate from an end segment
              if (x > first_q) begin
                seg_q <= '0;
                b0_q  <= first_q;
                b1_q  <= (k_q == PW'(1)) ? cur : second_q;
              end else begin
                seg_q <= k_q - PW'(1);
                b0_q  <= prev_q;
                b1_q  <= cur;
              end
              state_q <= S_V0;
            end else begin
              prev_q <= cur;
              k_q    <= k_q + PW'(1);
            end
          end
        end
        S_V0: begin
          den_q   <= DEN_W'(b1_q) - DEN_W'(b0_q);
          dx_q    <= DEN_W'(x) - DEN_W'(b0_q);
          state_q <= S_V1;
        end
        S_V1: begin
          v0_q <= val_rd_q;
          if (den_q == '0) begin
            res_q.interpolated <= '0;
            res_q.status       <= STAT_ZERO;
            res_valid_q        <= 1'b1;
            state_q            <= S_OUT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= dv * dx_q;
          state_q <= S_DIV0;
        end
        S_DIV0: begin
          neg_q   <= prod_q[PROD_W-1] ^ den_q[DEN_W-1];
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_stat_i.done) begin
            if (div_stat_i.ovf) begin
              res_q.interpolated <= neg_q ? DATA_MIN : DATA_MAX;
              res_q.status       <= STAT_SAT;
            end else if (sum > (DATA_W+3)'(DATA_MAX)) begin
              res_q.interpolated <= DATA_MAX;
              res_q.status       <= STAT_SAT;
            end else if (sum < (DATA_W+3)'(DATA_MIN)) begin
              res_q.interpolated <= DATA_MIN;
              res_q.status       <= STAT_SAT;
            end else begin
              res_q.interpolated <= DATA_W'(sum);
              res_q.status       <= STAT_OK;
            end
            res_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            res_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/piecewise_linear_interpolator.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Role                       Fields
// in_i     in   write / query beat         mode, row, point, data
// out_o    out  interpolated result beat   interpolated, status
// cfg_i    in   points_in_use write beat   data
//
// A store write or an unused mode returns to idle from the prepare state. A query searches the
// breakpoints in use up to the enclosing one, then fetches the two values, forms the product and
// runs the restoring divider; a zero-width segment skips the product and the divider, and a
// quotient overflow ends the division without iterating. Reset clears control and sets
// points_in_use to 16; the stores are undefined until written. The output register lets
// one result wait on a stalled out_o while the next query runs up to its hand-over.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int POINTS = POINTS_DEF,
  parameter int ROWS   = ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pli_item_if.sink    in_i,
  pli_result_if.source out_o,
  pli_cfg_if.sink     cfg_i
);

  logic [CNT_W-1:0] piu_q;
  item_t            item;
  logic             res_valid, res_ready;
  result_t          res;
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [QUO_W-1:0] div_quo;
  logic             out_valid_q;
  result_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= PIU_RESET;
    end else if (cfg_i.valid) begin
      piu_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  assign item.mode  = in_i.mode;
  assign item.row   = in_i.row;
  assign item.point = in_i.point;
  assign item.data  = in_i.data;

  pli_ctrl #(
    .POINTS (POINTS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .piu_i       (piu_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_stat_i  (div_stat),
    .div_quo_i   (div_quo)
  );

  pli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // output register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.interpolated = out_q.interpolated;
  assign out_o.status       = out_q.status;

endmodule

@@ rtl/core/pli_checker.sv @@
`timescale 1ns / 1ps

module pli_checker import pli_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] interpolated_i,
  input logic [STAT_W-1:0]        status_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(interpolated_i)
      && $stable(status_i))
    else $error("result beat changed while stalled");

  // every accepted item keeps the block busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == STAT_OK || status_i == STAT_SAT
      || status_i == STAT_ZERO))
    else $error("status code out of range");

  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_ZERO |-> interpolated_i == '0)
    else $error("zero-width segment with non-zero value");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_SAT
      |-> (interpolated_i == DATA_MAX || interpolated_i == DATA_MIN))
    else $error("saturated result not at a range limit");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .interpolated_i (out_o.interpolated),
  .status_i       (out_o.status)
);
